FILE: hdl/krmv_pkg.sv
// Shared types and constants for the keyed running mean and variance block.
// Depends on nothing; every other file of the block but krmv_ram imports it.
package krmv_pkg;

  // Saturation limits of the count and the variance.
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [62:0] VAR_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

  // Iterations of the shared divider and of the serial multiplier.
  localparam int DIV_STEPS = 64;
  localparam int MUL_STEPS = 33;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_MISS,
    ST_PREP,
    ST_MGO,
    ST_MWAIT,
    ST_MEAN,
    ST_MINIT,
    ST_MUL,
    ST_ACC,
    ST_VGO,
    ST_VWAIT,
    ST_DONE
  } krmv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic search;
    logic alloc;
    logic full;
    logic prep;
    logic div_start;
    logic div_var;
    logic mean_upd;
    logic mul_init;
    logic mul_step;
    logic acc;
    logic out_load;
  } krmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic used_zero;
    logic key_hit;
    logic last_entry;
    logic table_full;
    logic div_done;
    logic mul_last;
    logic cnt_gt1;
    logic out_free;
  } krmv_status_t;

endpackage

FILE: hdl/krmv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module krmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/krmv_div.sv
// Iterative restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on krmv_pkg.
module krmv_div
  import krmv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_r, quo_r[63]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[31:0];
      quo_nxt = {quo_r[62:0], 1'b1};
    end else begin
      rem_nxt = trial[31:0];
      quo_nxt = {quo_r[62:0], 1'b0};
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/krmv_ctrl.sv
// Controller state machine: sequences search, allocation, division,
// multiplication and result hand-off. Depends on krmv_pkg.
module krmv_ctrl
  import krmv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  krmv_status_t st,
  output krmv_cmd_t    cmd
);

  krmv_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = st.used_zero ? ST_MISS : ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (st.key_hit) begin
          state_nxt = ST_PREP;
        end else if (st.last_entry) begin
          state_nxt = ST_MISS;
        end else begin
          cmd.search = 1'b1;
        end
      end
      ST_MISS: begin
        if (st.table_full) begin
          cmd.full  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.alloc = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MGO;
      end
      ST_MGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (st.div_done) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd.mean_upd = 1'b1;
        state_nxt    = ST_MINIT;
      end
      ST_MINIT: begin
        cmd.mul_init = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.cnt_gt1 ? ST_VGO : ST_DONE;
      end
      ST_VGO: begin
        cmd.div_start = 1'b1;
        cmd.div_var   = 1'b1;
        state_nxt     = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (st.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/krmv_dp.sv
// Datapath: key and statistics tables, Welford update arithmetic and the
// result register. Depends on krmv_pkg, krmv_ram and krmv_div.
module krmv_dp
  import krmv_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  krmv_cmd_t           cmd,
  output krmv_status_t        st,
  input  logic [31:0]         in_key,
  input  logic signed [31:0]  in_sample_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_new_entry,
  output logic                out_table_full,
  output logic [31:0]         out_sample_count,
  output logic signed [31:0]  out_running_mean,
  output logic [62:0]         out_sample_variance
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

  // Transaction and table bookkeeping.
  logic [31:0]        key_r;
  logic signed [31:0] v_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [USED_W-1:0]  used_r;
  logic               fresh_r;
  logic               full_r;

  // Arithmetic registers.
  logic [31:0]        c_r;
  logic signed [31:0] m0_r;
  logic signed [31:0] m1_r;
  logic [63:0]        s_r;
  logic signed [32:0] d_r;
  logic [65:0]        mul_a_r;
  logic [32:0]        mul_b_r;
  logic [65:0]        mul_acc_r;
  logic [5:0]         mul_cnt_r;

  // Output register.
  logic               out_valid_r;
  logic               out_new_entry_r;
  logic               out_table_full_r;
  logic [31:0]        out_count_r;
  logic [31:0]        out_mean_r;
  logic [62:0]        out_var_r;

  logic [31:0]  key_rdata;
  logic [127:0] stat_rdata;
  logic [127:0] stat_wdata;
  logic [63:0]  div_dividend;
  logic [31:0]  div_divisor;
  logic [63:0]  quo;
  logic         div_done;

  logic [31:0]        cnt_old;
  logic signed [31:0] m0_in;
  logic [63:0]        s_in;
  logic [32:0]        d_mag;
  logic signed [32:0] q_signed;
  logic signed [33:0] m1_wide;
  logic signed [32:0] e_val;
  logic [32:0]        e_mag;
  logic [63:0]        prod_sat;
  logic [64:0]        s_sum;
  logic [63:0]        s_new;
  logic [62:0]        var_val;

  // Table index: starts at zero, steps during the search, or takes the
  // next free slot on allocation.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = '0;
    end else if (cmd.search) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.alloc) begin
      idx_nxt = used_r[IDX_W-1:0];
    end
  end

  // Both tables read at the next index, so their data always belongs to idx_r.
  krmv_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (used_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (idx_nxt),
    .rdata (key_rdata)
  );

  assign stat_wdata = {s_new, m1_r, c_r};

  krmv_ram #(.WIDTH(128), .DEPTH(TABLE_ENTRIES)) u_stat_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (idx_r),
    .wdata (stat_wdata),
    .raddr (idx_nxt),
    .rdata (stat_rdata)
  );

  // Shared divider: mean step divides |d| by the count, variance step
  // divides S by the count minus one.
  assign d_mag        = d_r[32] ? 33'(-d_r) : 33'(d_r);
  assign div_dividend = cmd.div_var ? s_r : {31'd0, d_mag};
  assign div_divisor  = cmd.div_var ? (c_r - 32'd1) : c_r;

  krmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // Old statistics of the slot; a fresh slot starts from zero.
  assign cnt_old = fresh_r ? 32'd0 : stat_rdata[31:0];
  assign m0_in   = fresh_r ? 32'sd0 : $signed(stat_rdata[63:32]);
  assign s_in    = fresh_r ? 64'd0 : stat_rdata[127:64];

  // New mean: truncated quotient carries the sign of the difference.
  assign q_signed = d_r[32] ? -$signed(quo[32:0]) : $signed(quo[32:0]);
  assign m1_wide  = $signed({{2{m0_r[31]}}, m0_r}) + $signed({q_signed[32], q_signed});

  // Second factor of the deviation product.
  assign e_val = $signed({v_r[31], v_r}) - $signed({m1_r[31], m1_r});
  assign e_mag = e_val[32] ? 33'(-e_val) : 33'(e_val);

  // Saturating product and saturating sum of squared deviations.
  assign prod_sat = (mul_acc_r[65:64] != 2'd0) ? '1 : mul_acc_r[63:0];
  assign s_sum    = {1'b0, s_r} + {1'b0, prod_sat};
  assign s_new    = s_sum[64] ? '1 : s_sum[63:0];

  // Variance saturates at the largest Q31.32 value, the most that fits 63 bits.
  assign var_val = quo[63] ? VAR_MAX : quo[62:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= '0;
    end else begin
      if (cmd.alloc) begin
        used_r <= used_r + USED_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.mul_init) begin
        mul_cnt_r <= '0;
      end else if (cmd.mul_step) begin
        mul_cnt_r <= mul_cnt_r + 6'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      key_r   <= in_key;
      v_r     <= in_sample_value;
      fresh_r <= 1'b0;
      full_r  <= 1'b0;
    end
    if (cmd.alloc) begin
      fresh_r <= 1'b1;
    end
    if (cmd.full) begin
      full_r <= 1'b1;
    end
    if (cmd.prep) begin
      c_r  <= (cnt_old == COUNT_MAX) ? COUNT_MAX : cnt_old + 32'd1;
      m0_r <= m0_in;
      s_r  <= s_in;
      d_r  <= $signed({v_r[31], v_r}) - $signed({m0_in[31], m0_in});
    end
    if (cmd.mean_upd) begin
      m1_r <= m1_wide[31:0];
    end
    if (cmd.mul_init) begin
      mul_a_r   <= {33'd0, e_mag};
      mul_b_r   <= d_mag;
      mul_acc_r <= '0;
    end else if (cmd.mul_step) begin
      if (mul_b_r[0]) begin
        mul_acc_r <= mul_acc_r + mul_a_r;
      end
      mul_a_r <= {mul_a_r[64:0], 1'b0};
      mul_b_r <= {1'b0, mul_b_r[32:1]};
    end
    if (cmd.acc) begin
      s_r <= s_new;
    end
    if (cmd.out_load) begin
      out_new_entry_r  <= fresh_r;
      out_table_full_r <= full_r;
      out_count_r      <= full_r ? 32'd0 : c_r;
      out_mean_r       <= full_r ? 32'd0 : m1_r;
      out_var_r        <= (full_r || c_r <= 32'd1) ? 63'd0 : var_val;
    end
  end

  // Status to the controller.
  assign st.used_zero  = (used_r == '0);
  assign st.key_hit    = (key_rdata == key_r);
  assign st.last_entry = (USED_W'(idx_r) + USED_W'(1) == used_r);
  assign st.table_full = (used_r == USED_W'(TABLE_ENTRIES));
  assign st.div_done   = div_done;
  assign st.mul_last   = (mul_cnt_r == 6'(MUL_STEPS - 1));
  assign st.cnt_gt1    = (c_r > 32'd1);
  assign st.out_free   = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_new_entry       = out_new_entry_r;
  assign out_table_full      = out_table_full_r;
  assign out_sample_count    = out_count_r;
  assign out_running_mean    = $signed(out_mean_r);
  assign out_sample_variance = out_var_r;

endmodule

FILE: hdl/keyed_running_mean_variance.sv
// Channel  | Ports                                         | Direction
// in       | in_valid, in_stall, in_key, in_sample_value   | samples in
// out      | out_valid, out_stall, out_new_entry,          | statistics out
//          | out_table_full, out_sample_count,             |
//          | out_running_mean, out_sample_variance         |
//
// One transaction at a time. After the accept, a hit searches the slots from slot 0
// up to its own, and a miss searches every used slot and then allocates one.
// The update then runs in order: preparation, the mean divide on the shared restoring
// divider, the mean update, the multiplier setup and the steps of the serial multiplier,
// the accumulate, the variance divide and the hand-off. A key's first sample skips the
// variance divide. A full table answers after the search, the miss check and the hand-off.
// Reset clears the allocation count and control state; no clearing pass runs.
// A stalled result waits in the output register while the next sample enters;
// the next result then holds the controller in its hand-off state until it leaves.
// Top level of the keyed running mean and variance block.
// Depends on krmv_pkg, krmv_ctrl and krmv_dp.
module keyed_running_mean_variance
  import krmv_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_key,
  input  logic signed [31:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_new_entry,
  output logic               out_table_full,
  output logic [31:0]        out_sample_count,
  output logic signed [31:0] out_running_mean,
  output logic [62:0]        out_sample_variance
);

  krmv_cmd_t    cmd;
  krmv_status_t st;

  // Sequencer.
  krmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables and arithmetic.
  krmv_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_key              (in_key),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_entry       (out_new_entry),
    .out_table_full      (out_table_full),
    .out_sample_count    (out_sample_count),
    .out_running_mean    (out_running_mean),
    .out_sample_variance (out_sample_variance)
  );

  // An accepted transaction blocks the input until it has been worked off.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A dropped sample carries no statistics.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (!out_new_entry && out_sample_count == 32'd0 && out_sample_variance == 63'd0))
    else $error("table-full result carries statistics");

  // A freshly allocated key has exactly one sample and no variance.
  a_fresh_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_entry) |->
      (out_sample_count == 32'd1 && out_sample_variance == 63'd0))
    else $error("new entry result inconsistent");

  // Allocation never happens on a full table.
  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !st.table_full)
    else $error("allocation on full table");

endmodule

FILE: test/keyed_running_mean_variance_tb.sv
// Testbench for keyed_running_mean_variance: drives keyed Q16.16 samples,
// predicts count, mean and variance per key, and checks every result.
// Depends on krmv_pkg and the keyed_running_mean_variance RTL.
module keyed_running_mean_variance_tb
  import krmv_pkg::*;
();

  localparam int SLOTS = 64;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_key;
  logic signed [31:0] in_sample_value;
  logic               out_valid;
  logic               out_stall;
  logic               out_new_entry;
  logic               out_table_full;
  logic [31:0]        out_sample_count;
  logic signed [31:0] out_running_mean;
  logic [62:0]        out_sample_variance;

  typedef struct packed {
    logic        new_entry;
    logic        table_full;
    logic [31:0] sample_count;
    logic [31:0] running_mean;
    logic [62:0] sample_variance;
  } stats_t;

  // Predictor state, one entry per slot.
  logic [31:0] slot_key   [SLOTS];
  logic [31:0] slot_count [SLOTS];
  logic [31:0] slot_mean  [SLOTS];
  logic [63:0] slot_sq_sum[SLOTS];
  int          slots_used;

  stats_t expected_stats[$];
  int     error_count = 0;
  longint cycle_count = 0;
  int     long_stall_pm;
  int     stall_left = 0;

  keyed_running_mean_variance #(.TABLE_ENTRIES(SLOTS)) dut (.*);

  // Clock, cycle limit.
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_running_mean_variance test failed");
      $finish;
    end
  end

  // Works out the statistics that one sample produces and updates the table.
  function automatic stats_t fold_sample(logic [31:0] key, logic [31:0] sample);
    stats_t r;
    int slot;
    logic [31:0] c;
    logic signed [63:0] v, m0, m1, d, e;
    logic [63:0] ad, ae;
    logic [127:0] prod;
    logic [64:0] sum;
    logic [63:0] var_q;
    r = '0;
    slot = -1;
    for (int i = 0; i < slots_used; i++) begin
      if (slot < 0 && slot_key[i] == key) slot = i;
    end
    if (slot < 0) begin
      if (slots_used >= SLOTS) begin
        r.table_full = 1'b1;
        return r;
      end
      slot = slots_used;
      slots_used++;
      slot_key[slot] = key;
      slot_count[slot] = '0;
      slot_mean[slot] = '0;
      slot_sq_sum[slot] = '0;
      r.new_entry = 1'b1;
    end
    c = slot_count[slot];
    if (c != COUNT_MAX) c = c + 32'd1;
    v = $signed(sample);
    m0 = $signed(slot_mean[slot]);
    d = v - m0;
    m1 = m0 + d / $signed({32'd0, c});
    e = v - m1;
    ad = d[63] ? -d : d;
    ae = e[63] ? -e : e;
    prod = ad * ae;
    sum = {1'b0, slot_sq_sum[slot]} + ((prod[127:64] != 0) ? 65'h0_FFFF_FFFF_FFFF_FFFF
                                                            : {1'b0, prod[63:0]});
    slot_sq_sum[slot] = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    slot_count[slot] = c;
    slot_mean[slot] = m1[31:0];
    if (c > 1) begin
      var_q = slot_sq_sum[slot] / {32'd0, c - 32'd1};
      r.sample_variance = var_q[63] ? VAR_MAX : var_q[62:0];
    end
    r.sample_count = c;
    r.running_mean = m1[31:0];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 400);
  endfunction

  // Sends one sample transaction and records its expected result. Valid stays
  // high after the accept until the next transaction, gap or drain begins.
  task automatic send_sample(logic [31:0] key, logic [31:0] sample, bit may_idle = 1);
    int g;
    g = may_idle ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key          <= key;
    in_sample_value <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_stats.insert(expected_stats.size(), fold_sample(key, sample));
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_stats.size() != 0) @(negedge clk);
  endtask

  // Result side stall pattern: mostly short stalls, now and then a long run.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 999) < long_stall_pm) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(20, 300);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // Checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: result with none expected, count %0d", $time, out_sample_count);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        if (out_new_entry !== want.new_entry) begin
          $display("%0t: new_entry exp %0b got %0b", $time, want.new_entry, out_new_entry);
          error_count++;
        end
        if (out_table_full !== want.table_full) begin
          $display("%0t: table_full exp %0b got %0b", $time, want.table_full,
                   out_table_full);
          error_count++;
        end
        if (out_sample_count !== want.sample_count) begin
          $display("%0t: sample_count exp %0d got %0d", $time, want.sample_count,
                   out_sample_count);
          error_count++;
        end
        if (out_running_mean !== want.running_mean) begin
          $display("%0t: running_mean exp %h got %h", $time, want.running_mean,
                   out_running_mean);
          error_count++;
        end
        if (out_sample_variance !== want.sample_variance) begin
          $display("%0t: sample_variance exp %h got %h", $time, want.sample_variance,
                   out_sample_variance);
          error_count++;
        end
      end
    end
  end

  // Extremes of both fields on a few keys, including the new-entry path.
  task automatic test_field_extremes();
    send_sample(32'h0000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(32'hAAAA_5555, 32'hFFFF_FFFF);
    send_sample(32'h5555_AAAA, 32'h0000_0001);
    send_sample(32'h5555_AAAA, 32'h0001_0000);
    send_sample(32'h5555_AAAA, 32'hFFFF_0000);
    wait_drained();
  endtask

  // Keys mostly from a small set so that counts grow and means settle.
  task automatic test_random_samples(int items, int key_span);
    logic [31:0] k, s;
    for (int n = 0; n < items; n++) begin
      k = (slots_used == 0 || $urandom_range(0, 9) < 8)
          ? 32'h1000 + $urandom_range(0, key_span - 1) : $urandom;
      case ($urandom_range(0, 3))
        0: s = $urandom;
        1: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                    : 32'h8000_0000 + $urandom_range(0, 255);
        default: s = 32'h0003_0000 + $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      endcase
      send_sample(k, s);
      if (n == items / 2) wait_drained();
    end
    wait_drained();
  endtask

  // Fills the table with fresh keys, then sends absent and stored keys.
  task automatic test_table_full();
    while (slots_used < SLOTS) send_sample($urandom | 32'h0100_0000, $urandom);
    for (int n = 0; n < 20; n++) send_sample(32'h00FF_0000 + n, $urandom);
    send_sample(slot_key[0], 32'h0000_0100);
    send_sample(slot_key[SLOTS - 1], 32'h0000_0200);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key = '0;
    in_sample_value = '0;
    slots_used = 0;
    long_stall_pm = 2;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_random_samples(600, 24);
    long_stall_pm = 10;
    test_random_samples(600, 8);
    long_stall_pm = 2;
    test_table_full();
    test_random_samples(600, 64);
    repeat (200) @(negedge clk);
    if (error_count == 0) $display("keyed_running_mean_variance test passed");
    else $display("keyed_running_mean_variance test failed");
    $finish;
  end

endmodule
